@@ hdl/pqmm_pkg.sv @@
// ----------------------------------------------------------------------------
// pqmm_pkg
// shared types and constants for the per-queue message mailbox
// ----------------------------------------------------------------------------
package pqmm_pkg;

    localparam int CMD_W    = 1;
    localparam int QUEUE_W  = 6;
    localparam int MSG_W    = 64;
    localparam int STATUS_W = 2;

    // slave tdata: queue then message, padded to whole bytes
    localparam int S_TDATA_W = ((QUEUE_W + MSG_W + 7) / 8) * 8;
    localparam int M_TDATA_W = MSG_W;

    localparam logic [CMD_W-1:0] CMD_SEND = 1'b0;
    localparam logic [CMD_W-1:0] CMD_RECV = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;

    // depth of the queue between the classifier and the store side
    localparam int FIFO_DEPTH = 4;

    typedef enum logic [2:0] {
        OP_WRITE  = 3'b001,
        OP_READ   = 3'b010,
        OP_STATUS = 3'b100
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [STATUS_W-1:0] status;
    } t_cmd;

endpackage

@@ hdl/per_queue_message_mailbox.sv @@
// ----------------------------------------------------------------------------
// per_queue_message_mailbox
// per-queue ring buffers of 64-bit messages with send and receive transfers
// ----------------------------------------------------------------------------
// Each of QUEUES receiver queues owns a ring of SLOTS 64-bit messages with its
// own read and write pointer. A send (tuser 0) stores the message at the write
// pointer and reports an overrun when the pointer lands on the read pointer; a
// receive (tuser 1) returns the oldest message or reports empty. Every input
// transfer gives exactly one output transfer, in order. The block sustains one
// transfer per cycle unless output stalls fill the queue: the pointer table is
// read and written back in one pass, with a bypass for back-to-back items on
// the same queue. A result passes the pointer-side register, then a four-entry
// queue that absorbs output stalls, then the two message-store registers.
// Queue indices of QUEUES or more are treated as nonexistent.
module per_queue_message_mailbox #(
    parameter int QUEUES = 64,
    parameter int SLOTS  = 1024
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [pqmm_pkg::S_TDATA_W-1:0]    i_s_tdata,  // queue, message, pad
    input  logic [pqmm_pkg::CMD_W-1:0]        i_s_tuser,  // cmd
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [pqmm_pkg::M_TDATA_W-1:0]    o_m_tdata,  // message_res
    output logic [pqmm_pkg::STATUS_W-1:0]     o_m_tuser   // status
);

    import pqmm_pkg::*;

    localparam int AW    = $clog2(QUEUES * SLOTS);
    localparam int CMD_B = $bits(t_cmd);
    localparam int FW    = CMD_B + AW + MSG_W;

    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    t_cmd             f_cmd;
    logic [AW-1:0]    f_addr;
    logic [MSG_W-1:0] f_msg;
    logic [FW-1:0]    fifo_out;
    t_cmd             b_cmd;

    pqmm_front #(
        .QUEUES (QUEUES),
        .SLOTS  (SLOTS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_cmd     (i_s_tuser),
        .i_queue   (i_s_tdata[QUEUE_W-1:0]),
        .i_message (i_s_tdata[QUEUE_W+MSG_W-1:QUEUE_W]),
        .o_push    (push),
        .i_full    (full),
        .o_cmd     (f_cmd),
        .o_addr    (f_addr),
        .o_message (f_msg)
    );

    pqmm_fifo #(
        .WIDTH (FW)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  ({f_cmd, f_addr, f_msg}),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (fifo_out)
    );

    assign b_cmd = t_cmd'(fifo_out[FW-1:AW+MSG_W]);

    pqmm_back #(
        .DEPTH (QUEUES * SLOTS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (empty),
        .o_pop     (pop),
        .i_cmd     (b_cmd),
        .i_addr    (fifo_out[AW+MSG_W-1:MSG_W]),
        .i_message (fifo_out[MSG_W-1:0]),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_status  (o_m_tuser),
        .o_message (o_m_tdata)
    );

endmodule

@@ hdl/pqmm_ram.sv @@
// ----------------------------------------------------------------------------
// pqmm_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module pqmm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/pqmm_front.sv @@
// ----------------------------------------------------------------------------
// pqmm_front
// accepts items, reads and updates the queue pointers, classifies each item
// ----------------------------------------------------------------------------
module pqmm_front #(
    parameter int QUEUES = 64,
    parameter int SLOTS  = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [pqmm_pkg::CMD_W-1:0]     i_cmd,
    input  logic [pqmm_pkg::QUEUE_W-1:0]   i_queue,
    input  logic [pqmm_pkg::MSG_W-1:0]     i_message,
    output logic                           o_push,
    input  logic                           i_full,
    output pqmm_pkg::t_cmd                 o_cmd,
    output logic [$clog2(QUEUES*SLOTS)-1:0] o_addr,
    output logic [pqmm_pkg::MSG_W-1:0]     o_message
);

    import pqmm_pkg::*;

    localparam int QAW = $clog2(QUEUES);
    localparam int PW  = $clog2(SLOTS);
    localparam int AW  = $clog2(QUEUES * SLOTS);

    logic             accept;
    logic             s1_fire;
    logic [QAW-1:0]   in_qa;
    logic             in_range;

    logic             r_s1_vld;
    logic [CMD_W-1:0] r_s1_cmd;
    logic [QAW-1:0]   r_s1_qa;
    logic             r_s1_inr;
    logic [AW-1:0]    r_s1_base;
    logic [MSG_W-1:0] r_s1_msg;
    logic             r_vld_hit;
    logic             r_fwd;
    logic [2*PW-1:0]  r_fwd_ptr;
    logic [QUEUES-1:0] r_ptr_vld;

    logic [2*PW-1:0]  ram_rdata;
    logic [2*PW-1:0]  ptr;
    logic [2*PW-1:0]  n_ptr;
    logic [PW-1:0]    rp;
    logic [PW-1:0]    wp;
    logic [PW-1:0]    rp_next;
    logic [PW-1:0]    wp_next;
    t_cmd             cmd;
    logic [AW-1:0]    addr;

    assign in_qa    = QAW'(i_queue);
    assign in_range = 32'(i_queue) < QUEUES;
    assign s1_fire  = r_s1_vld && !i_full;
    assign o_ready  = !r_s1_vld || s1_fire;
    assign accept   = i_valid && o_ready;

    pqmm_ram #(
        .WIDTH (2 * PW),
        .DEPTH (QUEUES)
    ) u_ptr_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && r_s1_inr),
        .i_waddr (r_s1_qa),
        .i_wdata (n_ptr),
        .i_re    (accept),
        .i_raddr (in_qa),
        .o_rdata (ram_rdata)
    );

    // a queue never written yet reads as zero pointers
    assign ptr = r_fwd ? r_fwd_ptr : (r_vld_hit ? ram_rdata : '0);
    assign rp  = ptr[PW-1:0];
    assign wp  = ptr[2*PW-1:PW];
    assign rp_next = (rp == PW'(SLOTS - 1)) ? '0 : rp + 1'b1;
    assign wp_next = (wp == PW'(SLOTS - 1)) ? '0 : wp + 1'b1;

    always_comb begin
        n_ptr      = ptr;
        cmd.op     = OP_STATUS;
        cmd.status = ST_OK;
        addr       = r_s1_base + AW'(wp);
        if (!r_s1_inr) begin
            cmd.status = (r_s1_cmd == CMD_RECV) ? ST_EMPTY : ST_OK;
        end else if (r_s1_cmd == CMD_SEND) begin
            cmd.op     = OP_WRITE;
            n_ptr      = {wp_next, rp};
            cmd.status = (wp_next == rp) ? ST_OVERRUN : ST_OK;
        end else if (rp == wp) begin
            cmd.status = ST_EMPTY;
        end else begin
            cmd.op = OP_READ;
            addr   = r_s1_base + AW'(rp);
            n_ptr  = {wp, rp_next};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_ptr_vld <= '0;
            r_fwd     <= 1'b0;
            r_vld_hit <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (s1_fire) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_fire && r_s1_inr) begin
                r_ptr_vld[r_s1_qa] <= 1'b1;
            end
            if (accept) begin
                // same queue as the item leaving now: ram read is stale
                r_fwd     <= s1_fire && r_s1_inr && (in_qa == r_s1_qa);
                r_vld_hit <= in_range && r_ptr_vld[in_qa];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_cmd  <= i_cmd;
            r_s1_qa   <= in_qa;
            r_s1_inr  <= in_range;
            r_s1_base <= AW'(in_qa) * AW'(SLOTS);
            r_s1_msg  <= i_message;
            r_fwd_ptr <= n_ptr;
        end
    end

    assign o_push    = s1_fire;
    assign o_cmd     = cmd;
    assign o_addr    = addr;
    assign o_message = r_s1_msg;

endmodule

@@ hdl/pqmm_fifo.sv @@
// ----------------------------------------------------------------------------
// pqmm_fifo
// short register queue between the classifier and the store side
// ----------------------------------------------------------------------------
module pqmm_fifo #(
    parameter int WIDTH = 90
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    import pqmm_pkg::*;

    localparam int IW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [FIFO_DEPTH];
    logic [IW-1:0]    r_head;
    logic [IW-1:0]    r_tail;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= (r_tail == IW'(FIFO_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= (r_head == IW'(FIFO_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

endmodule

@@ hdl/pqmm_back.sv @@
// ----------------------------------------------------------------------------
// pqmm_back
// carries out classified items on the message store and drives the result
// ----------------------------------------------------------------------------
module pqmm_back #(
    parameter int DEPTH = 65536
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_empty,
    output logic                            o_pop,
    input  pqmm_pkg::t_cmd                  i_cmd,
    input  logic [$clog2(DEPTH)-1:0]        i_addr,
    input  logic [pqmm_pkg::MSG_W-1:0]      i_message,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [pqmm_pkg::STATUS_W-1:0]   o_status,
    output logic [pqmm_pkg::MSG_W-1:0]      o_message
);

    import pqmm_pkg::*;

    logic                r_b_vld;
    t_cmd                r_b_cmd;
    logic                r_o_vld;
    logic [STATUS_W-1:0] r_o_status;
    logic [MSG_W-1:0]    r_o_msg;
    logic                b_adv;
    logic                pop;
    logic [MSG_W-1:0]    rdata;

    assign b_adv = r_b_vld && (!r_o_vld || i_ready);
    assign pop   = !i_empty && (!r_b_vld || b_adv);

    pqmm_ram #(
        .WIDTH (MSG_W),
        .DEPTH (DEPTH)
    ) u_msg_ram (
        .i_clk   (i_clk),
        .i_we    (pop && (i_cmd.op == OP_WRITE)),
        .i_waddr (i_addr),
        .i_wdata (i_message),
        .i_re    (pop && (i_cmd.op == OP_READ)),
        .i_raddr (i_addr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
            r_o_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_b_vld <= 1'b1;
            end else if (b_adv) begin
                r_b_vld <= 1'b0;
            end
            if (b_adv) begin
                r_o_vld <= 1'b1;
            end else if (i_ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_b_cmd <= i_cmd;
        end
        if (b_adv) begin
            r_o_status <= r_b_cmd.status;
            r_o_msg    <= (r_b_cmd.op == OP_READ) ? rdata : '0;
        end
    end

    assign o_pop     = pop;
    assign o_valid   = r_o_vld;
    assign o_status  = r_o_status;
    assign o_message = r_o_msg;

endmodule
